>>> design/ltbp_pkg.sv
// ============================================================================
// ltbp_pkg: shared types and constants of the luma threshold bit packer
// Holds the luma weights, the dark limit, register indexes, layout codes and
// the result word type that travels from the packer to the output queue.
// ============================================================================
package ltbp_pkg;

    // Luma weights and the threshold below which a pixel counts as dark.
    localparam logic [16:0] LUMA_R     = 17'd77;
    localparam logic [16:0] LUMA_G     = 17'd150;
    localparam logic [16:0] LUMA_B     = 17'd29;
    localparam logic [16:0] DARK_LIMIT = 17'd32768;

    // Bit position of the last pixel in a packed byte.
    localparam logic [2:0] BYTE_LAST_BIT = 3'd7;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_CHANNEL_LAYOUT = 2'd2;

    // Channel layout codes; the unused code behaves as gray.
    localparam logic [1:0] LAYOUT_GRAY = 2'd0;
    localparam logic [1:0] LAYOUT_RGB  = 2'd1;
    localparam logic [1:0] LAYOUT_BGR  = 2'd2;

    // One result word.
    typedef struct packed {
        logic [7:0] packed_byte;
        logic       row_end;
        logic       image_end;
    } result_word_t;

endpackage

>>> design/ltbp_luma.sv
// ============================================================================
// ltbp_luma: dark pixel classifier
// Orders the three channels by layout, forms 77R + 150G + 29B and flags the
// pixel as dark when the luma is below the limit.
// ============================================================================
module ltbp_luma (
    input  logic [7:0] first_channel,
    input  logic [7:0] second_channel,
    input  logic [7:0] third_channel,
    input  logic [1:0] channel_layout,
    output logic       dark
);
    import ltbp_pkg::*;

    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [16:0] luma;

    // Map the channels onto red, green and blue.
    always_comb
    begin
        unique case (channel_layout)
            LAYOUT_RGB:
            begin
                red   = first_channel;
                green = second_channel;
                blue  = third_channel;
            end
            LAYOUT_BGR:
            begin
                red   = third_channel;
                green = second_channel;
                blue  = first_channel;
            end
            default:
            begin
                red   = first_channel;
                green = first_channel;
                blue  = first_channel;
            end
        endcase
    end

    // Weighted sum; the largest value is 256 * 255, which fits in 17 bits.
    assign luma = ({9'd0, red} * LUMA_R) + ({9'd0, green} * LUMA_G)
                + ({9'd0, blue} * LUMA_B);

    assign dark = (luma < DARK_LIMIT);

endmodule

>>> design/ltbp_out_queue.sv
// ============================================================================
// ltbp_out_queue: two-word output buffer
// An output register plus a skid register, so the input side stalls only
// from a registered full flag and never combinationally from the receiver.
// ============================================================================
module ltbp_out_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ltbp_pkg::result_word_t push_word,
    output logic                  full,
    output logic                  out_valid,
    input  logic                  out_stall,
    output ltbp_pkg::result_word_t out_word
);
    import ltbp_pkg::*;

    logic         main_valid_reg;
    logic         skid_valid_reg;
    result_word_t main_word_reg;
    result_word_t skid_word_reg;
    logic         pop;
    logic         main_load;

    assign pop       = main_valid_reg && !out_stall;
    assign main_load = pop || !main_valid_reg;

    // Valid flags of the two entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_load)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= push;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Word storage follows the same moves as the flags.
    always_ff @(posedge clk)
    begin
        if (main_load)
        begin
            if (skid_valid_reg)
            begin
                main_word_reg <= skid_word_reg;
                if (push)
                begin
                    skid_word_reg <= push_word;
                end
            end
            else if (push)
            begin
                main_word_reg <= push_word;
            end
        end
        else if (push)
        begin
            skid_word_reg <= push_word;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_word  = main_word_reg;

endmodule

>>> design/luma_threshold_bit_packer.sv
// ============================================================================
// luma_threshold_bit_packer: one-bit bitmap packer with luma threshold
// Classifies each pixel as dark or light and packs the bits LSB first.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one pixel word per cycle in
//   raster order: first_channel, second_channel, third_channel.
//   Output channel (out_valid / out_stall) carries one packed byte word with
//   row_end and image_end flags. A word leaves after the eighth pixel of a
//   byte or after the last pixel of a row, whichever comes first.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) sets width,
//   height and channel layout; cfg_ready is always high. Write only while
//   no pixel is in flight; counters are not cleared by a write.
//   An emitted word is registered in the output buffer before it leaves.
//   Throughput is one pixel per cycle while in_stall is low, set by the
//   combinational classify and pack step feeding a two-word output buffer.
//   Reset sets width and height to 1, layout to gray and both counters to
//   zero. When the receiver stalls, the buffer holds up to two words; after
//   that in_stall rises until a word is taken.
// ============================================================================
module luma_threshold_bit_packer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  first_channel,
    input  logic [7:0]  second_channel,
    input  logic [7:0]  third_channel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  packed_byte,
    output logic        row_end,
    output logic        image_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import ltbp_pkg::*;

    logic [15:0]  image_width_reg;
    logic [15:0]  image_height_reg;
    logic [1:0]   channel_layout_reg;
    logic [15:0]  column_count_reg;
    logic [15:0]  column_count_next;
    logic [15:0]  row_count_reg;
    logic [15:0]  row_count_next;
    logic [7:0]   partial_byte_reg;
    logic [7:0]   partial_byte_next;

    logic         in_accept;
    logic         dark;
    logic [2:0]   bit_index;
    logic [16:0]  column_plus;
    logic [16:0]  row_plus;
    logic         at_row_end;
    logic         at_image_end;
    logic [7:0]   merged_byte;
    logic         emit;
    logic         queue_full;
    result_word_t result_word;
    result_word_t out_word;

    assign cfg_ready = 1'b1;
    assign in_stall  = queue_full;
    assign in_accept = in_valid && !in_stall;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= 16'd1;
            image_height_reg   <= 16'd1;
            channel_layout_reg <= LAYOUT_GRAY;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:    image_width_reg    <= cfg_data;
                CFG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data;
                CFG_CHANNEL_LAYOUT: channel_layout_reg <= cfg_data[1:0];
                default:            ;
            endcase
        end
    end

    ltbp_luma u_luma (
        .first_channel  (first_channel),
        .second_channel (second_channel),
        .third_channel  (third_channel),
        .channel_layout (channel_layout_reg),
        .dark           (dark)
    );

    // Position checks against the current image size.
    assign bit_index    = column_count_reg[2:0];
    assign column_plus  = {1'b0, column_count_reg} + 17'd1;
    assign row_plus     = {1'b0, row_count_reg} + 17'd1;
    assign at_row_end   = (column_plus >= {1'b0, image_width_reg});
    assign at_image_end = (row_plus >= {1'b0, image_height_reg});

    // Merge the pixel bit and decide whether a byte leaves.
    assign merged_byte = partial_byte_reg | (dark ? (8'd1 << bit_index) : 8'd0);
    assign emit        = at_row_end || (bit_index == BYTE_LAST_BIT);

    always_comb
    begin
        result_word.packed_byte = merged_byte;
        result_word.row_end     = at_row_end;
        result_word.image_end   = at_row_end && at_image_end;
    end

    // Next counter and partial byte values.
    always_comb
    begin
        partial_byte_next = emit ? 8'd0 : merged_byte;
        if (at_row_end)
        begin
            column_count_next = 16'd0;
            row_count_next    = at_image_end ? 16'd0 : row_plus[15:0];
        end
        else
        begin
            column_count_next = column_plus[15:0];
            row_count_next    = row_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= 16'd0;
            row_count_reg    <= 16'd0;
            partial_byte_reg <= 8'd0;
        end
        else if (in_accept)
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            partial_byte_reg <= partial_byte_next;
        end
    end

    ltbp_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept && emit),
        .push_word (result_word),
        .full      (queue_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    assign packed_byte = out_word.packed_byte;
    assign row_end     = out_word.row_end;
    assign image_end   = out_word.image_end;

    // An image end word is always also a row end word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!image_end || row_end))
        else $error("image_end without row_end");

    // A pixel that ends its row sends the column counter back to zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && at_row_end) |=> (column_count_reg == 16'd0))
        else $error("column counter not cleared at row end");

    // Emitting a byte clears the partial byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && emit) |=> (partial_byte_reg == 8'd0))
        else $error("partial byte not cleared after emit");

    // The input stalls only while a word waits on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top: testbench of the luma threshold bit packer
// Drives pixel words with random gaps, stalls the packed byte output at
// random, and checks every byte word against a predictor that classifies
// each pixel by luma and packs the bits LSB first. The predictor keeps its
// own copy of the column and row counters and of the three registers.
// ============================================================================
module tb_top;

    import ltbp_pkg::*;

    // Register index with no register behind it, and the spare layout code.
    localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;
    localparam logic [1:0] LAYOUT_SPARE    = 2'd3;

    localparam int unsigned RANDOM_PIXELS = 600;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned REPORT_LIMIT  = 10;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic [7:0]  first_channel  = 8'd0;
    logic [7:0]  second_channel = 8'd0;
    logic [7:0]  third_channel  = 8'd0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic [7:0]  packed_byte;
    logic        row_end;
    logic        image_end;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index      = 2'd0;
    logic [15:0] cfg_data       = 16'd0;

    // Predictor copy of the registers and the packing state.
    logic [15:0] width_q;
    logic [15:0] height_q;
    logic [1:0]  layout_q;
    logic [15:0] column_q;
    logic [15:0] row_q;
    logic [7:0]  byte_q;

    result_word_t expected_bytes[$];
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count    = 0;
    int unsigned  in_idle_pct    = 24;
    int unsigned  out_stall_pct  = 24;

    luma_threshold_bit_packer DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .first_channel  (first_channel),
        .second_channel (second_channel),
        .third_channel  (third_channel),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .packed_byte    (packed_byte),
        .row_end        (row_end),
        .image_end      (image_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    // Run limit: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Receiver back pressure, redrawn at every falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    task automatic log_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("tb_top: mismatch at %0t: %s", $realtime, what);
    endtask

    // Dark test on the luma; the spare layout code counts as gray.
    function automatic bit luma_is_dark(input logic [7:0] c0, c1, c2);
        int unsigned r, g, b;
        case (layout_q)
            LAYOUT_RGB:
            begin
                r = 32'(c0); g = 32'(c1); b = 32'(c2);
            end
            LAYOUT_BGR:
            begin
                r = 32'(c2); g = 32'(c1); b = 32'(c0);
            end
            default:
            begin
                r = 32'(c0); g = 32'(c0); b = 32'(c0);
            end
        endcase
        return (r * 32'(LUMA_R) + g * 32'(LUMA_G) + b * 32'(LUMA_B)) < 32'(DARK_LIMIT);
    endfunction

    // Advances the packing state by one pixel; returns 1 when a byte word
    // leaves. The bound compares are >= so that a lowered register ends the
    // row or image at the next chance.
    function automatic bit pack_pixel(input logic [7:0] c0, c1, c2,
                                      output result_word_t word);
        logic [2:0]  bit_pos;
        bit          last_col;
        bit          last_row;
        bit_pos  = column_q[2:0];
        last_col = (32'(column_q) + 32'd1) >= 32'(width_q);
        word     = '0;
        if (luma_is_dark(c0, c1, c2))
            byte_q[bit_pos] = 1'b1;
        if (!last_col)
        begin
            column_q = column_q + 16'd1;
            if (bit_pos != BYTE_LAST_BIT)
                return 1'b0;
            word.packed_byte = byte_q;
            byte_q = 8'd0;
            return 1'b1;
        end
        last_row = (32'(row_q) + 32'd1) >= 32'(height_q);
        word.packed_byte = byte_q;
        word.row_end     = 1'b1;
        word.image_end   = last_row;
        byte_q   = 8'd0;
        column_q = 16'd0;
        row_q    = last_row ? 16'd0 : row_q + 16'd1;
        return 1'b1;
    endfunction

    // Sends one pixel word and records the byte word it is due to cause.
    task automatic send_pixel(input logic [7:0] c0, c1, c2);
        result_word_t word;
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        first_channel  <= c0;
        second_channel <= c1;
        third_channel  <= c2;
        do
            @(posedge clk);
        while (in_stall);
        if (pack_pixel(c0, c1, c2, word))
            expected_bytes = {expected_bytes, word};
    endtask

    // Random pixel; a quarter are gray values around the dark threshold.
    task automatic send_random_pixel();
        logic [7:0] level;
        if ($urandom_range(3) == 0)
        begin
            level = 8'($urandom_range(120, 135));
            send_pixel(level, level, level);
        end
        else
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Stops the input and waits until every expected word has come out,
    // then allows for a pixel that is still in flight without a word.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            CFG_IMAGE_WIDTH:    width_q  = data;
            CFG_IMAGE_HEIGHT:   height_q = data;
            CFG_CHANNEL_LAYOUT: layout_q = data[1:0];
            default:            ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Checks each accepted byte word against the oldest expectation.
    always @(posedge clk)
    begin
        result_word_t got;
        result_word_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got = {packed_byte, row_end, image_end};
            if (expected_bytes.size() == 0)
                log_mismatch($sformatf("unexpected word byte %02h row_end %0b image_end %0b",
                                       got.packed_byte, got.row_end, got.image_end));
            else
            begin
                want = expected_bytes.pop_front();
                if (got.packed_byte !== want.packed_byte || got.row_end !== want.row_end
                    || got.image_end !== want.image_end)
                    log_mismatch($sformatf(
                        "expected byte %02h row_end %0b image_end %0b, got %02h %0b %0b",
                        want.packed_byte, want.row_end, want.image_end,
                        got.packed_byte, got.row_end, got.image_end));
            end
        end
    end

    // Reset values: one-pixel image, gray, threshold on both sides.
    task automatic test_reset_defaults();
        send_pixel(8'h00, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'd127, 8'd0, 8'd0);
        send_pixel(8'd128, 8'd0, 8'd0);
    endtask

    // Each layout with a pixel whose class depends on channel order, plus
    // layout data with high bits set and the spare layout code.
    task automatic test_layouts();
        drain();
        write_reg(CFG_IMAGE_WIDTH, 16'd3);
        write_reg(CFG_IMAGE_HEIGHT, 16'd2);
        write_reg(CFG_CHANNEL_LAYOUT, {14'd0, LAYOUT_RGB});
        send_pixel(8'hFF, 8'd120, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'hFF);
        drain();
        write_reg(CFG_CHANNEL_LAYOUT, {14'h3FFF, LAYOUT_BGR});
        send_pixel(8'hFF, 8'd120, 8'h00);
        send_pixel(8'h00, 8'h00, 8'h00);
        drain();
        write_reg(CFG_CHANNEL_LAYOUT, {14'd0, LAYOUT_SPARE});
        send_pixel(8'd127, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00);
    endtask

    // Width and height of zero: every pixel ends its row and the image.
    // A write to the index with no register must change nothing.
    task automatic test_zero_bounds();
        drain();
        write_reg(CFG_IMAGE_WIDTH, 16'd0);
        write_reg(CFG_IMAGE_HEIGHT, 16'd0);
        write_reg(CFG_SPARE_INDEX, 16'hFFFF);
        send_pixel(8'h10, 8'h20, 8'h30);
        send_pixel(8'hF0, 8'hE0, 8'hD0);
    endtask

    // Registers lowered below the running counters, mid row and mid image.
    task automatic test_counter_past_bound();
        drain();
        write_reg(CFG_CHANNEL_LAYOUT, {14'd0, LAYOUT_GRAY});
        write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
        repeat (10) send_random_pixel();
        drain();
        write_reg(CFG_IMAGE_WIDTH, 16'd5);
        send_pixel(8'h00, 8'h00, 8'h00);
        drain();
        write_reg(CFG_IMAGE_WIDTH, 16'd1);
        repeat (3) send_random_pixel();
        drain();
        write_reg(CFG_IMAGE_HEIGHT, 16'd2);
        repeat (2) send_random_pixel();
    endtask

    // Random geometry and layout per phase; mostly whole images, sometimes
    // a broken-off stretch that leaves the counters mid image.
    task automatic test_random_images();
        int unsigned sent;
        int unsigned pixels;
        int unsigned full_w;
        int unsigned full_h;
        logic [15:0] w;
        logic [15:0] h;
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            drain();
            case ($urandom_range(9))
                0:       w = 16'd0;
                1:       w = 16'hFFFF;
                2:       w = 16'($urandom_range(9, 40));
                default: w = 16'($urandom_range(1, 12));
            endcase
            case ($urandom_range(7))
                0:       h = 16'd0;
                1:       h = 16'($urandom_range(1000, 65535));
                default: h = 16'($urandom_range(1, 4));
            endcase
            if ($urandom_range(3) != 0)
                write_reg(CFG_IMAGE_WIDTH, w);
            if ($urandom_range(3) != 0)
                write_reg(CFG_IMAGE_HEIGHT, h);
            if ($urandom_range(1) != 0)
                write_reg(CFG_CHANNEL_LAYOUT, 16'($urandom));
            if ($urandom_range(9) == 0)
                write_reg(CFG_SPARE_INDEX, 16'($urandom));

            // A long stretch in the middle runs with no gaps on either side.
            if (sent >= 200 && sent < 360)
            begin
                in_idle_pct   = 0;
                out_stall_pct = 0;
            end
            else
            begin
                in_idle_pct   = 24;
                out_stall_pct = 24;
            end

            full_w = (width_q == 16'd0) ? 1 : width_q;
            full_h = (height_q == 16'd0) ? 1 : height_q;
            if ($urandom_range(4) == 0)
                pixels = $urandom_range(1, 30);
            else
                pixels = (full_w * full_h > 150) ? 150 : full_w * full_h;
            repeat (pixels) send_random_pixel();
            sent += pixels;
        end
    endtask

    initial
    begin
        width_q  = 16'd1;
        height_q = 16'd1;
        layout_q = LAYOUT_GRAY;
        column_q = 16'd0;
        row_q    = 16'd0;
        byte_q   = 8'd0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_layouts();
        test_zero_bounds();
        test_counter_past_bound();
        test_random_images();

        drain();
        if (mismatch_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
